/* rtl/pfbs_pkg.sv */
// Package for the pump flow bisection solver: types, constants and the
// saturating Q.20 helper functions shared by the controller and datapath.
// No dependencies.
package pfbs_pkg;

   localparam int unsigned MaxHalvings = 100;
   localparam int unsigned IterWidth   = 7;
   localparam logic [63:0] SatMax      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SatMin      = 64'h8000_0000_0000_0001;
   localparam logic [63:0] AccLsb      = 64'd11;
   localparam logic [63:0] QFour       = 64'd4194304;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOBRACKET = 2'd1,
      ST_ITERLIMIT = 2'd2,
      ST_NEGDISC   = 2'd3
   } status_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_AREA_ONE  = 3'd0,
      REG_AREA_TWO  = 3'd1,
      REG_SLOPE     = 3'd2,
      REG_HEAD      = 3'd3,
      REG_LOSS_ONE  = 3'd4,
      REG_LOSS_TWO  = 3'd5,
      REG_VALVE_ONE = 3'd6,
      REG_VALVE_TWO = 3'd7
   } reg_index_type;

   // Micro-operations that the datapath runs, one per command.
   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } op_type;

   typedef enum logic [5:0] {
      S_IDLE, S_S1, S_S2, S_D0, S_D1, S_Q, S_I0, S_I1, S_I2, S_I3,
      S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_SQ, S_F0, S_F1, S_F2, S_FR,
      S_X2, S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_EVDONE,
      S_WAIT, S_OUT
   } state_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic [63:0] a;
      logic [63:0] b;
   } unit_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } unit_sts_type;

   function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64:63] == 2'b01) begin
         sadd = SatMax;
      end else if (s[64:63] == 2'b10 || s[63:0] == 64'h8000_0000_0000_0000) begin
         sadd = SatMin;
      end else begin
         sadd = s[63:0];
      end
   endfunction

   function automatic logic [63:0] sneg(input logic [63:0] a);
      sneg = (a == 64'h8000_0000_0000_0000) ? SatMax : (64'd0 - a);
   endfunction

   function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
      ssub = sadd(a, sneg(b));
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] a);
      mag = a[63] ? (64'd0 - a) : a;
   endfunction

   function automatic logic [63:0] signed_of(input logic [63:0] m, input logic neg);
      logic [63:0] c;
      c = m[63] ? SatMax : m;
      signed_of = neg ? (64'd0 - c) : c;
   endfunction

   function automatic logic [31:0] out32(input logic [63:0] v);
      if (!v[63] && v[62:31] != 32'd0) begin
         out32 = 32'h7FFF_FFFF;
      end else if (v[63] && v[62:31] != 32'hFFFF_FFFF) begin
         out32 = 32'h8000_0000;
      end else begin
         out32 = v[31:0];
      end
   endfunction

endpackage

/* rtl/pfbs_unit.sv */
// Multi-cycle arithmetic unit: Q.20 multiply (16-bit partial products),
// divide (restoring, one bit per cycle) and square root (one bit per cycle).
// Depends on pfbs_pkg.
module pfbs_unit
   import pfbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_cmd_type cmd,
   output unit_sts_type sts
);

   typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIN} ustate_type;

   ustate_type   ust_ff, ust_in;
   op_type       op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         neg_ff, neg_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic [63:0]  res_ff, res_in;

   logic [79:0]  pp;
   logic [64:0]  shr;
   logic [63:0]  cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         ust_ff <= U_IDLE;
      end else begin
         ust_ff <= ust_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   always_comb begin
      ust_in = ust_ff;
      op_in  = op_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      res_in = res_ff;
      pp     = 80'd0;
      shr    = 65'd0;
      cand   = 64'd0;
      sts.done   = 1'b0;
      sts.result = res_ff;
      unique case (ust_ff)
         U_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               neg_in = cmd.a[63] ^ cmd.b[63];
               acc_in = 128'd0;
               q_in   = 64'd0;
               rem_in = 64'd0;
               cnt_in = 7'd0;
               ust_in = U_RUN;
               if (cmd.op == OP_SQRT) begin
                  // The radicand is the value times 2^20, consumed two bits a cycle.
                  acc_in = {44'd0, cmd.a, 20'd0};
                  cnt_in = 7'd41;
               end else begin
                  a_in = mag(cmd.a);
                  b_in = mag(cmd.b);
               end
               if (cmd.op == OP_DIV) begin
                  a_in   = mag(cmd.a) << 20;
                  rem_in = mag(cmd.a) >> 44;
                  if (mag(cmd.b) == 64'd0) begin
                     res_in = (cmd.a == 64'd0) ? 64'd0 : (cmd.a[63] ? SatMin : SatMax);
                     ust_in = U_FIN;
                  end else if ((mag(cmd.a) >> 44) >= mag(cmd.b)) begin
                     res_in = neg_in ? SatMin : SatMax;
                     ust_in = U_FIN;
                  end
               end
            end
         end
         U_RUN: begin
            unique case (op_ff)
               OP_MUL: begin
                  // One 64x16 partial product per cycle, four partial products in all.
                  pp     = a_ff * b_ff[15:0];
                  acc_in = acc_ff + ({48'd0, pp} << {cnt_ff[1:0], 4'd0});
                  b_in   = b_ff >> 16;
                  cnt_in = cnt_ff + 7'd1;
                  if (cnt_ff[1:0] == 2'd3) begin
                     ust_in = U_FIN;
                     if (acc_in[127:84] != 44'd0) begin
                        res_in = neg_ff ? SatMin : SatMax;
                     end else begin
                        res_in = signed_of(acc_in[83:20], neg_ff);
                     end
                  end
               end
               OP_DIV: begin
                  shr  = {rem_ff, a_ff[63]};
                  a_in = a_ff << 1;
                  if (shr[64] || shr[63:0] >= b_ff) begin
                     rem_in = shr[63:0] - b_ff;
                     q_in   = {q_ff[62:0], 1'b1};
                  end else begin
                     rem_in = shr[63:0];
                     q_in   = {q_ff[62:0], 1'b0};
                  end
                  cnt_in = cnt_ff + 7'd1;
                  if (cnt_ff == 7'd63) begin
                     res_in = signed_of(q_in, neg_ff);
                     ust_in = U_FIN;
                  end
               end
               default: begin
                  // Digit-by-digit square root: bring down two radicand bits and
                  // try to subtract four times the root plus one.
                  shr    = {1'b0, rem_ff[61:0], acc_ff[83:82]};
                  cand   = {q_ff[61:0], 2'b01};
                  acc_in = acc_ff << 2;
                  if (shr[63:0] >= cand) begin
                     rem_in = shr[63:0] - cand;
                     q_in   = {q_ff[62:0], 1'b1};
                  end else begin
                     rem_in = shr[63:0];
                     q_in   = {q_ff[62:0], 1'b0};
                  end
                  cnt_in = cnt_ff - 7'd1;
                  if (cnt_ff == 7'd0) begin
                     res_in = q_in;
                     ust_in = U_FIN;
                  end
               end
            endcase
         end
         default: begin
            sts.done = 1'b1;
            ust_in   = U_IDLE;
         end
      endcase
   end

endmodule

/* rtl/pfbs_ctrl.sv */
// Controller for the pump flow bisection solver: sequences the evaluation
// of the balance equation and the bisection loop. Depends on pfbs_pkg.
module pfbs_ctrl
   import pfbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  prev_flow,
   input  logic [63:0]  tank,
   input  logic [63:0]  cfg_a1,
   input  logic [63:0]  cfg_a2,
   input  logic [63:0]  cfg_slope,
   input  logic [63:0]  cfg_head,
   input  logic [63:0]  cfg_l1,
   input  logic [63:0]  cfg_l2,
   input  logic [63:0]  cfg_v1,
   input  logic [63:0]  cfg_v2,
   output unit_cmd_type cmd,
   input  unit_sts_type sts,
   output logic         done,
   output logic [63:0]  res_flow,
   output logic [63:0]  res_recycle,
   output status_type   res_status
);

   // Phases of the solve, each ending with one evaluation.
   typedef enum logic [2:0] {P_LO, P_HI, P_MID, P_FINAL} phase_type;

   state_type   st_ff, st_in;
   phase_type   ph_ff, ph_in;
   logic [IterWidth-1:0] it_ff, it_in;
   logic [63:0] x_ff, x_in, s1_ff, s1_in, s2_ff, s2_in, d_ff, d_in, q_ff, q_in;
   logic [63:0] t0_ff, t0_in, t1_ff, t1_in, fr_ff, fr_in, x2_ff, x2_in;
   logic [63:0] acc_ff, acc_in, flo_ff, flo_in, rtb_ff, rtb_in, dx_ff, dx_in;
   logic [63:0] pt_ff, pt_in, hi_ff, hi_in;
   status_type  stat_ff, stat_in;
   logic        pend_ff, pend_in;
   state_type   nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
      end
      ph_ff <= ph_in;  it_ff <= it_in;  x_ff <= x_in;  s1_ff <= s1_in;
      s2_ff <= s2_in;  d_ff <= d_in;    q_ff <= q_in;  t0_ff <= t0_in;
      t1_ff <= t1_in;  fr_ff <= fr_in;  x2_ff <= x2_in; acc_ff <= acc_in;
      flo_ff <= flo_in; rtb_ff <= rtb_in; dx_ff <= dx_in; pt_ff <= pt_in;
      hi_ff <= hi_in;  stat_ff <= stat_in;
   end

   // Next-state logic: an operation state issues one unit command, then
   // waits for its completion before moving on.
   always_comb begin
      nx = st_ff;
      unique case (st_ff)
         S_S1: nx = S_S2;   S_S2: nx = S_D0;   S_D0: nx = S_D1;  S_D1: nx = S_Q;
         S_Q:  nx = S_I0;   S_I0: nx = S_I1;   S_I1: nx = S_I2;  S_I2: nx = S_I3;
         S_I3: nx = S_C0;   S_C0: nx = S_C1;   S_C1: nx = S_C2;  S_C2: nx = S_C3;
         S_C3: nx = S_C4;   S_C4: nx = S_C5;   S_C5: nx = S_SQ;  S_SQ: nx = S_F0;
         S_F0: nx = S_F1;   S_F1: nx = S_F2;   S_F2: nx = S_FR;  S_FR: nx = S_X2;
         S_X2: nx = S_A0;   S_A0: nx = S_A1;   S_A1: nx = S_A2;  S_A2: nx = S_A3;
         S_A3: nx = S_A4;   S_A4: nx = S_A5;   S_A5: nx = S_A6;  S_A6: nx = S_A7;
         S_A7: nx = S_A8;   S_A8: nx = S_EVDONE;
         default: nx = S_IDLE;
      endcase
   end

   always_comb begin
      st_in = st_ff;  ph_in = ph_ff;  it_in = it_ff;  x_in = x_ff;
      s1_in = s1_ff;  s2_in = s2_ff;  d_in = d_ff;    q_in = q_ff;
      t0_in = t0_ff;  t1_in = t1_ff;  fr_in = fr_ff;  x2_in = x2_ff;
      acc_in = acc_ff; flo_in = flo_ff; rtb_in = rtb_ff; dx_in = dx_ff;
      pt_in = pt_ff;  hi_in = hi_ff;  stat_in = stat_ff; pend_in = pend_ff;
      cmd.start = 1'b0; cmd.op = OP_MUL; cmd.a = 64'd0; cmd.b = 64'd0;
      done = 1'b0;
      if (pend_ff) begin
         // Waiting on the unit; store its result per state.
         if (sts.done) begin
            pend_in = 1'b0;
            unique case (st_ff)
               S_S1: s1_in = sts.result;
               S_S2: s2_in = sts.result;
               S_D0: d_in  = sts.result;
               S_Q:  q_in  = sts.result;
               S_I0: t0_in = sts.result;
               S_C0: t1_in = sts.result;
               S_C1: t1_in = sts.result;
               S_C2: t0_in = sts.result;
               S_C3: t0_in = sts.result;
               S_SQ: t1_in = sts.result;
               S_FR: fr_in = sts.result;
               S_X2: x2_in = sts.result;
               S_A0: t1_in = sts.result;
               S_A2: t1_in = sts.result;
               S_A3: t1_in = sts.result;
               S_A6: t1_in = sts.result;
               default: ;
            endcase
            st_in = nx;
         end
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (start) begin
                  pt_in = tank; hi_in = prev_flow << 1; x_in = 64'd0;
                  ph_in = P_LO; stat_in = ST_ITERLIMIT; it_in = '0;
                  st_in = S_S1;
               end
            end
            S_S1: begin cmd = '{1'b1, OP_MUL, cfg_a1, cfg_a1}; pend_in = 1'b1; end
            S_S2: begin cmd = '{1'b1, OP_MUL, cfg_a2, cfg_a2}; pend_in = 1'b1; end
            S_D0: begin cmd = '{1'b1, OP_MUL, s1_ff, cfg_l1}; pend_in = 1'b1; end
            S_D1: begin d_in = sadd(d_ff, cfg_v1); st_in = nx; end
            S_Q:  begin cmd = '{1'b1, OP_MUL, s1_ff, cfg_slope}; pend_in = 1'b1; end
            S_I0: begin cmd = '{1'b1, OP_MUL, cfg_slope, x_ff}; pend_in = 1'b1; end
            S_I1: begin t0_in = ssub(sneg(cfg_head), t0_ff); st_in = nx; end
            S_I2: begin t0_in = ssub(t0_ff, pt_ff); st_in = nx; end
            S_I3: begin acc_in = t0_ff; st_in = nx; end
            S_C0: begin cmd = '{1'b1, OP_MUL, s1_ff, d_ff}; pend_in = 1'b1; end
            S_C1: begin cmd = '{1'b1, OP_MUL, t1_ff, acc_ff}; pend_in = 1'b1; end
            S_C2: begin cmd = '{1'b1, OP_MUL, QFour, t1_ff}; pend_in = 1'b1; end
            S_C3: begin cmd = '{1'b1, OP_MUL, q_ff, q_ff}; t1_in = t0_ff;
                        pend_in = 1'b1; end
            S_C4: begin t0_in = ssub(t0_ff, t1_ff); st_in = nx; end
            S_C5: begin
               if (t0_ff[63]) begin
                  stat_in = ST_NEGDISC; st_in = S_OUT;
               end else begin
                  st_in = nx;
               end
            end
            S_SQ: begin cmd = '{1'b1, OP_SQRT, t0_ff, 64'd0}; pend_in = 1'b1; end
            S_F0: begin t1_in = sadd(q_ff, t1_ff); st_in = nx; end
            S_F1: begin t0_in = sadd(d_ff, d_ff); st_in = nx; end
            S_F2: st_in = nx;
            S_FR: begin cmd = '{1'b1, OP_DIV, t1_ff, t0_ff}; pend_in = 1'b1; end
            S_X2: begin cmd = '{1'b1, OP_MUL, x_ff, x_ff}; pend_in = 1'b1; end
            S_A0: begin cmd = '{1'b1, OP_MUL, x2_ff, cfg_l2}; pend_in = 1'b1; end
            S_A1: begin acc_in = sadd(sneg(cfg_head), t1_ff); st_in = nx; end
            S_A2: begin cmd = '{1'b1, OP_MUL, x2_ff, cfg_v2}; pend_in = 1'b1; end
            S_A3: begin cmd = '{1'b1, OP_DIV, t1_ff, s2_ff}; pend_in = 1'b1; end
            S_A4: begin acc_in = sadd(acc_ff, t1_ff); st_in = nx; end
            S_A5: begin t0_in = sadd(x_ff, fr_ff); st_in = nx; end
            S_A6: begin cmd = '{1'b1, OP_MUL, cfg_slope, t0_ff}; pend_in = 1'b1; end
            S_A7: begin acc_in = ssub(acc_ff, t1_ff); st_in = nx; end
            S_A8: begin acc_in = ssub(acc_ff, pt_ff); st_in = nx; end
            S_EVDONE: begin
               // acc_ff holds f(x) and fr_ff the recycle flow.
               unique case (ph_ff)
                  P_LO: begin
                     flo_in = acc_ff; x_in = hi_ff; ph_in = P_HI; st_in = S_I0;
                  end
                  P_HI: begin
                     if (!((flo_ff[63] && !acc_ff[63] && acc_ff != 64'd0) ||
                           (!flo_ff[63] && flo_ff != 64'd0 && acc_ff[63]))) begin
                        stat_in = ST_NOBRACKET; st_in = S_OUT;
                     end else begin
                        if (flo_ff[63]) begin
                           rtb_in = 64'd0; dx_in = hi_ff;
                        end else begin
                           rtb_in = hi_ff; dx_in = 64'd0 - hi_ff;
                        end
                        st_in = S_WAIT;
                     end
                  end
                  P_MID: begin
                     if (acc_ff[63] || acc_ff == 64'd0) begin
                        rtb_in = x_ff;
                     end
                     if (mag(dx_ff) < AccLsb || acc_ff == 64'd0) begin
                        stat_in = ST_OK; x_in = rtb_in; ph_in = P_FINAL; st_in = S_I0;
                     end else if (it_ff == IterWidth'(MaxHalvings)) begin
                        x_in = rtb_in; ph_in = P_FINAL; st_in = S_I0;
                     end else begin
                        st_in = S_WAIT;
                     end
                  end
                  default: st_in = S_OUT;
               endcase
            end
            S_WAIT: begin
               // Halve the step (toward zero) and evaluate the midpoint.
               dx_in = (dx_ff[63] && dx_ff[0]) ? ($signed(dx_ff) >>> 1) + 64'd1
                                               : $signed(dx_ff) >>> 1;
               x_in  = rtb_ff + dx_in;
               it_in = it_ff + 1'b1;
               ph_in = P_MID;
               st_in = S_I0;
            end
            default: begin
               done = 1'b1;
               st_in = S_IDLE;
            end
         endcase
      end
   end

   assign res_flow    = (stat_ff == ST_OK || stat_ff == ST_ITERLIMIT) ? rtb_ff : 64'd0;
   assign res_recycle = (stat_ff == ST_OK || stat_ff == ST_ITERLIMIT) ? fr_ff : 64'd0;
   assign res_status  = stat_ff;

endmodule

/* rtl/pump_flow_bisection_solver.sv */
// Pump flow bisection solver top: registers, stream ports, output register;
// uses pfbs_pkg, pfbs_ctrl and pfbs_unit.
// Each evaluation runs on the shared unit: nine multiplies, a root, two divides
// and 14 control steps; a solve makes 2 + halvings + 1 evaluations, with at
// most 100 halvings.
// One item at a time, next taken after the result leaves; sync reset restores defaults.
module pump_flow_bisection_solver
   import pfbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // previous_pump_flow[30:0], tank_pressure[61:31]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // pump_flow[31:0], recycle_flow[63:32],
                                     // total_flow[95:64], status[97:96]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [30:0] a1_ff, a2_ff, l1_ff, l2_ff, v1_ff, v2_ff;
   logic [31:0] slope_ff, head_ff;
   logic        busy_ff, busy_in;
   logic        ov_ff, ov_in;
   logic [103:0] od_ff, od_in;

   unit_cmd_type cmd;
   unit_sts_type sts;
   logic         done;
   logic [63:0]  rflow, rrec;
   status_type   rstat;
   logic         start;

   assign csr_ready  = 1'b1;
   // A new transaction is taken only when no solve runs and the output
   // register is empty, so a finished solve always finds room for its result.
   assign req_tready = !busy_ff && !ov_ff;
   assign start      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff <= 31'd1048576; a2_ff <= 31'd1048576; v1_ff <= 31'd1048576;
         l1_ff <= '0; l2_ff <= '0; v2_ff <= '0; slope_ff <= '0; head_ff <= '0;
         busy_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_AREA_ONE:  a1_ff    <= csr_data[30:0];
               REG_AREA_TWO:  a2_ff    <= csr_data[30:0];
               REG_SLOPE:     slope_ff <= csr_data;
               REG_HEAD:      head_ff  <= csr_data;
               REG_LOSS_ONE:  l1_ff    <= csr_data[30:0];
               REG_LOSS_TWO:  l2_ff    <= csr_data[30:0];
               REG_VALVE_ONE: v1_ff    <= csr_data[30:0];
               default:       v2_ff    <= csr_data[30:0];
            endcase
         end
      end
      od_ff <= od_in;
   end

   // The output register is loaded when the controller finishes and freed
   // by the result transaction.
   always_comb begin
      busy_in = busy_ff;
      ov_in   = ov_ff;
      od_in   = od_ff;
      if (rsp_tvalid && rsp_tready) begin
         ov_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
         ov_in   = 1'b1;
         od_in   = {6'd0, rstat, out32(sadd(rflow, rrec)), out32(rrec), out32(rflow)};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   pfbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .prev_flow   ({33'd0, req_tdata[30:0]}),
      .tank        ({33'd0, req_tdata[61:31]}),
      .cfg_a1      ({33'd0, a1_ff}),
      .cfg_a2      ({33'd0, a2_ff}),
      .cfg_slope   ({{32{slope_ff[31]}}, slope_ff}),
      .cfg_head    ({{32{head_ff[31]}}, head_ff}),
      .cfg_l1      ({33'd0, l1_ff}),
      .cfg_l2      ({33'd0, l2_ff}),
      .cfg_v1      ({33'd0, v1_ff}),
      .cfg_v2      ({33'd0, v2_ff}),
      .cmd         (cmd),
      .sts         (sts),
      .done        (done),
      .res_flow    (rflow),
      .res_recycle (rrec),
      .res_status  (rstat)
   );

   pfbs_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   // A solve never starts while the previous one is still running.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("item accepted during a solve");

   // A completed solve always loads the output register.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result lost");

   // Error results carry zero flows.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[97:96] == ST_NOBRACKET || rsp_tdata[97:96] == ST_NEGDISC))
      |-> rsp_tdata[95:0] == 96'd0) else $error("error result with flow");

endmodule

/* tb/sv/tb_pump_flow_bisection_solver.sv */
// Self-checking testbench for pump_flow_bisection_solver: directed table plus random
// operating points, checked against a bit-exact Q.20 bisection predictor.
// Depends on pfbs_pkg and the solver RTL.
module tb_pump_flow_bisection_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import pfbs_pkg::*;

   localparam longint FixMax    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint FourQ     = 64'sd4194304;
   localparam longint StepFloor = 64'sd11;
   localparam int     IdlePct   = 34;
   localparam int     HoldCycles = 20000;
   localparam int     StuckLimit = 200000;
   localparam int     NumPhases  = 7;

   typedef struct packed {
      logic [31:0] pump;
      logic [31:0] recycle;
      logic [31:0] total;
      status_type  status;
   } flow_result_type;

   typedef struct {
      int          phase;
      logic [30:0] prev_flow;
      logic [30:0] tank;
      bit          typed;     // Expected result is written in the row.
      status_type  status;    // Typed rows always carry zero flows.
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;   // previous_pump_flow[30:0], tank_pressure[61:31]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // pump_flow[31:0], recycle_flow[63:32],
                              // total_flow[95:64], status[97:96]
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   pump_flow_bisection_solver uut (.*);

   // Predictor copy of the configuration registers, held as Q.20 in 64 bits.
   longint area_one, area_two, slope, head, loss_one, loss_two, valve_one, valve_two;

   flow_result_type pending_flows[$];
   int  fail_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  hold_request = 0;
   bit  no_idle = 0;
   int  status_hits[4] = '{0, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Saturating Q.20 arithmetic, mirroring the block's number format.
   // ---------------------------------------------------------------------
   function automatic longint fix_add(longint a, longint b);
      logic signed [64:0] s;
      s = a + b;
      if (s > FixMax) return FixMax;
      if (s < -FixMax) return -FixMax;
      return s[63:0];
   endfunction

   function automatic longint fix_sub(longint a, longint b);
      return fix_add(a, -b);
   endfunction

   function automatic logic [63:0] abs_of(longint a);
      return a < 0 ? 64'd0 - a : a;
   endfunction

   function automatic longint apply_sign(logic [63:0] m, bit neg);
      if (m > FixMax) m = FixMax;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      logic [127:0] p;
      bit neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
      if (p[127:84] != 0) return neg ? -FixMax : FixMax;
      return apply_sign(p[83:20], neg);
   endfunction

   function automatic longint fix_div(longint n, longint d);
      logic [127:0] num, q;
      bit neg;
      neg = (n < 0) != (d < 0);
      if (d == 0) begin
         if (n == 0) return 0;
         return n < 0 ? -FixMax : FixMax;
      end
      num = {44'd0, abs_of(n), 20'd0};
      q = num / {64'd0, abs_of(d)};
      if (q[127:64] != 0) return neg ? -FixMax : FixMax;
      return apply_sign(q[63:0], neg);
   endfunction

   function automatic longint fix_sqrt(longint v);
      logic [127:0] target, c, r;
      target = {64'd0, v} << 20;
      r = 0;
      for (int b = 41; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= target) r = c;
      end
      return r[63:0];
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Balance residual and recycle flow at pump flow x; 0 on negative discriminant.
   function automatic bit balance_at(longint x, longint tank, output longint resid,
                                     output longint recyc);
      longint s1, s2, dd, qq, inner, disc, x2, acc;
      s1 = fix_mul(area_one, area_one);
      s2 = fix_mul(area_two, area_two);
      dd = fix_add(fix_mul(s1, loss_one), valve_one);
      qq = fix_mul(s1, slope);
      inner = fix_sub(fix_sub(-head, fix_mul(slope, x)), tank);
      disc = fix_sub(fix_mul(qq, qq), fix_mul(FourQ, fix_mul(fix_mul(s1, dd), inner)));
      resid = 0;
      recyc = 0;
      if (disc < 0) return 1'b0;
      recyc = fix_div(fix_add(qq, fix_sqrt(disc)), fix_add(dd, dd));
      x2 = fix_mul(x, x);
      acc = -head;
      acc = fix_add(acc, fix_mul(x2, loss_two));
      acc = fix_add(acc, fix_div(fix_mul(x2, valve_two), s2));
      acc = fix_sub(acc, fix_mul(slope, fix_add(x, recyc)));
      resid = fix_sub(acc, tank);
      return 1'b1;
   endfunction

   function automatic flow_result_type solve_pump_flow(logic [30:0] prev_flow,
                                                       logic [30:0] tank_in);
      flow_result_type res;
      longint tank, hi_end, f_lo, f_hi, f_mid, fr, root, step, mid;
      status_type st;
      tank = tank_in;
      hi_end = 2 * longint'(prev_flow);
      res = '{32'd0, 32'd0, 32'd0, ST_ITERLIMIT};
      st = ST_ITERLIMIT;
      if (!balance_at(0, tank, f_lo, fr) || !balance_at(hi_end, tank, f_hi, fr)) begin
         res.status = ST_NEGDISC;
         return res;
      end
      if (!((f_lo < 0 && f_hi > 0) || (f_lo > 0 && f_hi < 0))) begin
         res.status = ST_NOBRACKET;
         return res;
      end
      // Start from the end where the residual is negative and walk toward the root.
      if (f_lo < 0) begin
         root = 0;
         step = hi_end;
      end else begin
         root = hi_end;
         step = -hi_end;
      end
      for (int j = 1; j <= MaxHalvings; j++) begin
         step = step / 2;
         mid = root + step;
         if (!balance_at(mid, tank, f_mid, fr)) begin
            res.status = ST_NEGDISC;
            return res;
         end
         if (f_mid <= 0) root = mid;
         if (abs_of(step) < StepFloor || f_mid == 0) begin
            st = ST_OK;
            break;
         end
      end
      // The recycle flow is reported at the final estimate, not the last midpoint.
      if (!balance_at(root, tank, f_mid, fr)) begin
         res.status = ST_NEGDISC;
         return res;
      end
      res.pump = clamp32(root);
      res.recycle = clamp32(fr);
      res.total = clamp32(fix_add(root, fr));
      res.status = st;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random backpressure, one long hold-off on request, checks.
   // ---------------------------------------------------------------------
   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   int hold_left = 0;

   always @(posedge clock) begin
      flow_result_type got, exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                    status_type'(rsp_tdata[97:96])};
            results_seen++;
            if (pending_flows.size() == 0) begin
               $display("%0t: result transaction with nothing expected, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               exp_r = pending_flows.pop_front();
               compare_field("pump_flow", exp_r.pump, got.pump);
               compare_field("recycle_flow", exp_r.recycle, got.recycle);
               compare_field("total_flow", exp_r.total, got.total);
               compare_field("status", 32'(exp_r.status), 32'(got.status));
               status_hits[got.status]++;
            end
         end
         // The hold-off is counted here so the sender keeps offering meanwhile.
         if (hold_request != 0) begin
            hold_left = HoldCycles;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // Watchdog: any channel that moves a transaction resets the count.
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request and register side.
   // ---------------------------------------------------------------------
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_AREA_ONE:  area_one  = value[30:0];
         REG_AREA_TWO:  area_two  = value[30:0];
         REG_SLOPE:     slope     = longint'($signed(value));
         REG_HEAD:      head      = longint'($signed(value));
         REG_LOSS_ONE:  loss_one  = value[30:0];
         REG_LOSS_TWO:  loss_two  = value[30:0];
         REG_VALVE_ONE: valve_one = value[30:0];
         REG_VALVE_TWO: valve_two = value[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offers one request transaction and records what it must produce.
   task automatic send_flow_item(logic [30:0] prev_flow, logic [30:0] tank, bit typed,
                                 status_type typed_status);
      flow_result_type exp_r;
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, tank, prev_flow};
      do @(posedge clock); while (!req_tready);
      if (typed) exp_r = '{32'd0, 32'd0, 32'd0, typed_status};
      else exp_r = solve_pump_flow(prev_flow, tank);
      pending_flows.push_back(exp_r);
      items_sent++;
      // Random gaps between requests; valid is only lowered when a gap follows.
      if (!no_idle && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_flows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register settings per phase, in index order. Phase 0 keeps the reset values
   // and phase 3 is drawn at random.
   logic [31:0] phase_regs[NumPhases][8] = '{
      '{32'h0010_0000, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0},
      '{32'h0010_0000, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000,
        32'h0010_0000, 32'h0},
      '{32'h0010_0000, 32'h0010_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
        32'h0010_0000, 32'h0},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h0008_0000, 32'h0008_0000, 32'hFFFC_0000, 32'h00A0_0000, 32'h0010_0000,
        32'h0, 32'h0020_0000, 32'h0010_0000},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
   };
   int random_per_phase[NumPhases] = '{10, 40, 8, 30, 12, 40, 8};

   // Directed rows. After reset the residual is minus the tank pressure at any
   // flow, so nothing is bracketed; a very negative pump head turns the
   // discriminant negative at the first evaluation.
   stim_row_type directed[] = '{
      '{0, 31'h0,        31'h0,        1'b1, ST_NOBRACKET},
      '{0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, ST_NOBRACKET},
      '{0, 31'h7FFFFFFF, 31'h0,        1'b1, ST_NOBRACKET},
      '{0, 31'h0,        31'h7FFFFFFF, 1'b1, ST_NOBRACKET},
      '{0, 31'h00100000, 31'h00100000, 1'b1, ST_NOBRACKET},
      '{1, 31'h00100000, 31'h00100000, 1'b0, ST_OK},
      '{1, 31'h00200000, 31'h00400000, 1'b0, ST_OK},
      '{1, 31'h00000001, 31'h00000000, 1'b0, ST_OK},
      '{1, 31'h00010000, 31'h00000001, 1'b0, ST_OK},
      '{1, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, ST_OK},
      '{2, 31'h0,        31'h0,        1'b1, ST_NEGDISC},
      '{2, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, ST_NEGDISC},
      '{2, 31'h00100000, 31'h00000001, 1'b1, ST_NEGDISC},
      '{4, 31'h00100000, 31'h00100000, 1'b0, ST_OK},
      '{4, 31'h7FFFFFFF, 31'h0,        1'b0, ST_OK},
      '{5, 31'h00400000, 31'h00100000, 1'b0, ST_OK},
      '{5, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, ST_OK},
      '{6, 31'h00100000, 31'h00100000, 1'b0, ST_OK},
      '{6, 31'h7FFFFFFF, 31'h0,        1'b0, ST_OK}
   };

   initial begin
      logic [30:0] prev_flow, tank;
      int width;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = REG_AREA_ONE;
      csr_data = '0;
      area_one = 64'sd1048576;
      area_two = 64'sd1048576;
      valve_one = 64'sd1048576;
      slope = 0; head = 0; loss_one = 0; loss_two = 0; valve_two = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph != 0) begin
            // The sender pauses here until every result of the phase has come.
            drain_results();
            for (int r = 0; r < 8; r++) begin
               write_reg(reg_index_type'(r),
                         ph == 3 ? ($urandom() >> $urandom_range(0, 24)) | (r < 2 ? 32'h1 : 32'h0)
                                 : phase_regs[ph][r]);
            end
         end
         no_idle = (ph == 5);
         if (ph == 1) hold_request = 1;
         foreach (directed[k]) begin
            if (directed[k].phase == ph) begin
               send_flow_item(directed[k].prev_flow, directed[k].tank, directed[k].typed,
                              directed[k].status);
            end
         end
         for (int n = 0; n < random_per_phase[ph]; n++) begin
            // Mostly modest brackets keep the halving count low; about one item in eight
            // spans the whole field.
            if ($urandom_range(7) == 0) prev_flow = 31'($urandom());
            else prev_flow = 31'($urandom_range(0, 1 << 18));
            width = $urandom_range(1, 31);
            tank = 31'($urandom() & ((32'd1 << width) - 1));
            send_flow_item(prev_flow, tank, 1'b0, ST_OK);
         end
      end
      drain_results();
      repeat (200) @(posedge clock);

      $display("Covered %0d requests and %0d results over %0d register settings;",
               items_sent, results_seen, NumPhases);
      $display("status counts ok=%0d unbracketed=%0d limit=%0d negative_disc=%0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (fail_count == 0 && pending_flows.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
